/* rtl/core/fspc_pkg.sv */
// Package for the filtered speed PID controller.
// Holds the sequencer-to-datapath control types, register indexes and fixed constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fspc_pkg;

  // Field and port widths
  localparam int SAMPLE_W   = 10;
  localparam int LEVEL_W    = 8;
  localparam int STEP_W     = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int GAIN_W     = 24;
  localparam int TARGET_W   = 8;

  // Shared multiplier operand and product widths
  localparam int MUL_W  = 24;
  localparam int PROD_W = 2 * MUL_W;

  // Loop arithmetic widths
  localparam int SETPOINT_W = 17;
  localparam int SPEED_W    = 23;
  localparam int ERROR_W    = 24;
  localparam int DERIV_W    = 25;
  localparam int INTEG_W    = 40;
  localparam int ACC_W      = 66;
  localparam int CLAMP_W    = 7;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_TARGET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D       = 2'd3;

  // |step| * 65536 / 14 = |step| * 4681 + |step| / 7
  localparam logic [MUL_W-1:0] SPEED_MUL  = 24'd4681;
  // floor(x / 7) = (x * 1171) >> 13 for any 10-bit x
  localparam logic [MUL_W-1:0] DIV7_RECIP = 24'd1171;
  localparam int               DIV7_SHIFT = 13;
  // Gain sum is Q28 (Q16 error times Q12 gain)
  localparam int               SUM_SHIFT  = 28;
  localparam logic [CLAMP_W-1:0] LEVEL_MAX = 7'd100;
  // floor(x / 100) = (x * 41944) >> 22 for any 15-bit x
  localparam logic [MUL_W-1:0] LEVEL_RECIP = 24'd41944;
  localparam int               LEVEL_SHIFT = 22;

  // Integral saturation bounds
  localparam logic [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
  localparam logic [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

  // Operand pair fed to the shared multiplier
  typedef enum logic [3:0] {
    MUL_HOLD,
    MUL_SAMPLE_LEN,
    MUL_TOTAL_RECIP,
    MUL_MAG_SPEED,
    MUL_MAG_RECIP7,
    MUL_ERR_KP,
    MUL_INT_LO_KI,
    MUL_INT_HI_KI,
    MUL_DER_KD,
    MUL_LEVEL_SCALE
  } mul_sel_t;

  // Register update performed by the datapath in a program step
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_WINDOW,
    ACT_TOTAL,
    ACT_AVERAGE,
    ACT_SETPOINT,
    ACT_SPEED,
    ACT_ERROR,
    ACT_INTEGRAL,
    ACT_MAGS,
    ACT_ACC_ERR,
    ACT_ACC_INT_LO,
    ACT_ACC_INT_HI,
    ACT_ACC_DER,
    ACT_CLAMP,
    ACT_FINISH_SCALE,
    ACT_FINISH_ZERO
  } act_t;

  // Control bundle from the sequencer to the window and the datapath
  typedef struct packed {
    logic     start;
    mul_sel_t mul_sel;
    act_t     act;
  } dp_ctrl_t;

endpackage

`default_nettype wire

/* rtl/core/filtered_speed_pid_controller.sv */
// Top level of the filtered speed PID controller.
// Connects the sequencer, the sample window and the datapath.
// Depends on fspc_pkg, fspc_seq, fspc_window and fspc_datapath.
`timescale 1ns / 1ps
`default_nettype none

// Each transferred adc_sample goes into a WINDOW_LENGTH-entry ring window (the first
// sample after reset stands for the whole window); the result carries the window average
// as filtered_angle, its change as angle_step, and a PID drive_level computed against
// speed_target. A small microcode program runs every item through one shared 24x24
// multiplier; when the gain sum is not positive it skips the level scaling and publishes
// a zero drive_level. Its final step waits while the output register holds a result that
// was not taken, and a new item is taken only once the program is back in idle. A
// finished result waits in the output register while the next item is taken and worked
// on. Configuration registers may be written only while the block is idle.

module filtered_speed_pid_controller #(
  parameter int WINDOW_LENGTH = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [fspc_pkg::SAMPLE_W-1:0]       adc_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [fspc_pkg::LEVEL_W-1:0]        drive_level,
  output logic [fspc_pkg::SAMPLE_W-1:0]       filtered_angle,
  output logic signed [fspc_pkg::STEP_W-1:0]  angle_step,
  input  logic                                cfg_write,
  input  logic [fspc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fspc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import fspc_pkg::*;

  dp_ctrl_t            ctrl;
  logic                acc_nonpos;
  logic [SAMPLE_W-1:0] sample;
  logic [SAMPLE_W-1:0] old_sample;
  logic                primed;

  // Program sequencer and handshakes
  fspc_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .acc_nonpos (acc_nonpos),
    .ctrl       (ctrl)
  );

  // Sample ring window
  fspc_window #(
    .WINDOW_LENGTH (WINDOW_LENGTH)
  ) u_window (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .adc_sample (adc_sample),
    .sample     (sample),
    .old_sample (old_sample),
    .primed     (primed)
  );

  // Arithmetic, loop state and result registers
  fspc_datapath #(
    .WINDOW_LENGTH (WINDOW_LENGTH)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (ctrl),
    .sample         (sample),
    .old_sample     (old_sample),
    .primed         (primed),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .acc_nonpos     (acc_nonpos),
    .drive_level    (drive_level),
    .filtered_angle (filtered_angle),
    .angle_step     (angle_step)
  );

endmodule

`default_nettype wire

/* rtl/core/fspc_window.sv */
// Sample ring window of the filtered speed PID controller.
// Holds the window memory, write position and the first-sample fill logic.
// Depends on fspc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fspc_window #(
  parameter int WINDOW_LENGTH = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  fspc_pkg::dp_ctrl_t                 ctrl,
  input  logic [fspc_pkg::SAMPLE_W-1:0]      adc_sample,
  output logic [fspc_pkg::SAMPLE_W-1:0]      sample,
  output logic [fspc_pkg::SAMPLE_W-1:0]      old_sample,
  output logic                               primed
);
  import fspc_pkg::*;

  localparam int POS_W = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW_LENGTH - 1);

  logic [SAMPLE_W-1:0] mem [0:WINDOW_LENGTH-1];
  logic [SAMPLE_W-1:0] rd_data;
  logic [SAMPLE_W-1:0] fill_sample;
  logic [POS_W-1:0]    pos;
  logic                lap_done;
  logic                commit;

  assign commit = (ctrl.act == ACT_WINDOW);

  // Capture the sample and read the entry it replaces on transfer; write it back in the step after
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      sample  <= adc_sample;
      rd_data <= mem[pos];
    end
    if (commit) begin
      mem[pos] <= sample;
    end
  end

  // Remember the first sample; it stands in for every entry until the first lap completes
  always_ff @(posedge clk) begin
    if (commit && !primed) begin
      fill_sample <= sample;
    end
  end

  // Advance the write position and track the first lap
  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      lap_done <= 1'b0;
      primed   <= 1'b0;
    end else if (commit) begin
      primed <= 1'b1;
      if (pos == POS_LAST) begin
        pos      <= '0;
        lap_done <= 1'b1;
      end else begin
        pos <= pos + POS_W'(1);
      end
    end
  end

  // Entry being replaced: the new sample itself on the very first transfer
  always_comb begin
    if (!primed) begin
      old_sample = sample;
    end else if (lap_done) begin
      old_sample = rd_data;
    end else begin
      old_sample = fill_sample;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/fspc_datapath.sv */
// Datapath of the filtered speed PID controller.
// Holds configuration registers, the shared 24x24 multiplier, loop state and result registers.
// Depends on fspc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fspc_datapath #(
  parameter int WINDOW_LENGTH = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  fspc_pkg::dp_ctrl_t                  ctrl,
  input  logic [fspc_pkg::SAMPLE_W-1:0]       sample,
  input  logic [fspc_pkg::SAMPLE_W-1:0]       old_sample,
  input  logic                                primed,
  input  logic                                cfg_write,
  input  logic [fspc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fspc_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                acc_nonpos,
  output logic [fspc_pkg::LEVEL_W-1:0]        drive_level,
  output logic [fspc_pkg::SAMPLE_W-1:0]       filtered_angle,
  output logic signed [fspc_pkg::STEP_W-1:0]  angle_step
);
  import fspc_pkg::*;

  localparam int TOTAL_W   = $clog2(1023 * WINDOW_LENGTH + 1);
  localparam int AVG_LOG   = $clog2(WINDOW_LENGTH);
  localparam int AVG_SHIFT = TOTAL_W + AVG_LOG;
  localparam int AVG_RECIP = ((1 << AVG_SHIFT) + WINDOW_LENGTH - 1) / WINDOW_LENGTH;

  // Configuration
  logic [TARGET_W-1:0] speed_target;
  logic [GAIN_W-1:0]   gain_p;
  logic [GAIN_W-1:0]   gain_i;
  logic [GAIN_W-1:0]   gain_d;

  // Loop state and working registers
  logic [MUL_W-1:0]      op_a;
  logic [MUL_W-1:0]      op_b;
  logic [PROD_W-1:0]     prod;
  logic [SAMPLE_W-1:0]   old_val;
  logic                  first;
  logic [TOTAL_W-1:0]    total;
  logic [SAMPLE_W-1:0]   prev_avg;
  logic [SAMPLE_W-1:0]   avg;
  logic [STEP_W-1:0]     step;
  logic [SAMPLE_W-1:0]   mag;
  logic [SETPOINT_W-1:0] setpoint;
  logic [SPEED_W-1:0]    speed_part;
  logic [ERROR_W-1:0]    error;
  logic [ERROR_W-1:0]    last_error;
  logic [ERROR_W-1:0]    emag;
  logic [INTEG_W-1:0]    integral;
  logic [INTEG_W-1:0]    imag;
  logic [DERIV_W-1:0]    deriv;
  logic [ERROR_W-1:0]    dmag;
  logic [ACC_W-1:0]      acc;
  logic [CLAMP_W-1:0]    lvl;

  // Combinational helpers
  logic [SAMPLE_W-1:0]  avg_new;
  logic [STEP_W-1:0]    step_new;
  logic [SPEED_W-1:0]   speed_sum;
  logic [INTEG_W:0]     integ_sum;
  logic [ACC_W-1:0]     term;
  logic                 term_neg;
  logic [ACC_W-1:0]     acc_next;
  logic [ACC_W-SUM_SHIFT-1:0] acc_units;
  logic [14:0]          lvl_x255;

  // Write configuration registers; each of the four indexes selects one register
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_target <= '0;
      gain_p       <= '0;
      gain_i       <= '0;
      gain_d       <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_SPEED_TARGET: speed_target <= cfg_data[TARGET_W-1:0];
        CFG_GAIN_P:       gain_p       <= cfg_data[GAIN_W-1:0];
        CFG_GAIN_I:       gain_i       <= cfg_data[GAIN_W-1:0];
        CFG_GAIN_D:       gain_d       <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Select the multiplier operands for this step
  assign lvl_x255 = {lvl, 8'b0} - 15'(lvl);

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (ctrl.mul_sel)
      MUL_SAMPLE_LEN: begin
        op_a = MUL_W'(sample);
        op_b = MUL_W'(WINDOW_LENGTH);
      end
      MUL_TOTAL_RECIP: begin
        op_a = MUL_W'(total);
        op_b = MUL_W'(AVG_RECIP);
      end
      MUL_MAG_SPEED: begin
        op_a = MUL_W'(mag);
        op_b = SPEED_MUL;
      end
      MUL_MAG_RECIP7: begin
        op_a = MUL_W'(mag);
        op_b = DIV7_RECIP;
      end
      MUL_ERR_KP: begin
        op_a = emag;
        op_b = gain_p;
      end
      MUL_INT_LO_KI: begin
        op_a = imag[MUL_W-1:0];
        op_b = gain_i;
      end
      MUL_INT_HI_KI: begin
        op_a = MUL_W'(imag[INTEG_W-1:MUL_W]);
        op_b = gain_i;
      end
      MUL_DER_KD: begin
        op_a = dmag;
        op_b = gain_d;
      end
      MUL_LEVEL_SCALE: begin
        op_a = MUL_W'(lvl_x255);
        op_b = LEVEL_RECIP;
      end
      default: ;
    endcase
  end

  // Shared multiplier: the product is registered and lands in the step after its operands are selected
  always_ff @(posedge clk) begin
    if (ctrl.mul_sel != MUL_HOLD) begin
      prod <= PROD_W'(op_a) * PROD_W'(op_b);
    end
  end

  // Average, angle step, speed, integral sum and accumulator units
  assign avg_new   = prod[AVG_SHIFT +: SAMPLE_W];
  assign step_new  = {1'b0, avg_new} - {1'b0, prev_avg};
  assign speed_sum = speed_part + SPEED_W'(prod[DIV7_SHIFT +: 8]);
  assign integ_sum = {integral[INTEG_W-1], integral}
                   + {{(INTEG_W-ERROR_W+1){error[ERROR_W-1]}}, error};
  assign acc_units = acc[ACC_W-1:SUM_SHIFT];

  // Signed gain term to fold into the accumulator
  always_comb begin
    term     = '0;
    term_neg = 1'b0;
    case (ctrl.act)
      ACT_ACC_ERR: begin
        term     = ACC_W'(prod);
        term_neg = error[ERROR_W-1];
      end
      ACT_ACC_INT_LO: begin
        term     = ACC_W'(prod);
        term_neg = integral[INTEG_W-1];
      end
      ACT_ACC_INT_HI: begin
        term     = {2'b0, prod[INTEG_W-1:0], {MUL_W{1'b0}}};
        term_neg = integral[INTEG_W-1];
      end
      ACT_ACC_DER: begin
        term     = ACC_W'(prod);
        term_neg = deriv[DERIV_W-1];
      end
      default: ;
    endcase
  end

  assign acc_next   = term_neg ? (acc - term) : (acc + term);
  assign acc_nonpos = acc[ACC_W-1] || (acc == '0);

  // Loop state with defined reset values
  always_ff @(posedge clk) begin
    if (rst) begin
      total      <= '0;
      prev_avg   <= '0;
      integral   <= '0;
      last_error <= '0;
    end else begin
      case (ctrl.act)
        ACT_WINDOW: begin
          if (!primed) begin
            prev_avg <= sample;
          end
        end
        ACT_TOTAL: begin
          total <= (first ? prod[TOTAL_W-1:0] : total) - TOTAL_W'(old_val)
                 + TOTAL_W'(sample);
        end
        ACT_AVERAGE: begin
          prev_avg <= avg_new;
        end
        ACT_INTEGRAL: begin
          if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
            integral <= integ_sum[INTEG_W] ? INTEG_MIN : INTEG_MAX;
          end else begin
            integral <= integ_sum[INTEG_W-1:0];
          end
          last_error <= error;
        end
        default: ;
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    case (ctrl.act)
      ACT_WINDOW: begin
        old_val <= old_sample;
        first   <= !primed;
      end
      ACT_AVERAGE: begin
        avg  <= avg_new;
        step <= step_new;
        mag  <= step_new[STEP_W-1] ? SAMPLE_W'(-step_new) : step_new[SAMPLE_W-1:0];
      end
      ACT_SETPOINT: begin
        setpoint <= {1'b0, speed_target, speed_target}
                  + SETPOINT_W'(speed_target == 8'hFF);
      end
      ACT_SPEED: begin
        speed_part <= prod[SPEED_W-1:0];
      end
      ACT_ERROR: begin
        error <= {{(ERROR_W-SETPOINT_W){1'b0}}, setpoint} - {1'b0, speed_sum};
      end
      ACT_INTEGRAL: begin
        deriv <= {error[ERROR_W-1], error} - {last_error[ERROR_W-1], last_error};
        emag  <= error[ERROR_W-1] ? (-error) : error;
        acc   <= '0;
      end
      ACT_MAGS: begin
        imag <= integral[INTEG_W-1] ? (-integral) : integral;
        dmag <= deriv[DERIV_W-1] ? ERROR_W'(-deriv) : deriv[ERROR_W-1:0];
      end
      ACT_ACC_ERR, ACT_ACC_INT_LO, ACT_ACC_INT_HI, ACT_ACC_DER: begin
        acc <= acc_next;
      end
      ACT_CLAMP: begin
        lvl <= (acc_units > (ACC_W-SUM_SHIFT)'(LEVEL_MAX)) ? LEVEL_MAX
                                                          : acc_units[CLAMP_W-1:0];
      end
      default: ;
    endcase
  end

  // Load the result registers when the sequencer publishes a result
  always_ff @(posedge clk) begin
    case (ctrl.act)
      ACT_FINISH_SCALE: begin
        drive_level    <= prod[LEVEL_SHIFT +: LEVEL_W];
        filtered_angle <= avg;
        angle_step     <= step;
      end
      ACT_FINISH_ZERO: begin
        drive_level    <= '0;
        filtered_angle <= avg;
        angle_step     <= step;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/fspc_seq.sv */
// Microcode sequencer of the filtered speed PID controller.
// Holds the control program, the step counter, the handshakes and the output valid flag.
// Depends on fspc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fspc_seq (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  logic               acc_nonpos,
  output fspc_pkg::dp_ctrl_t ctrl
);
  import fspc_pkg::*;

  typedef logic [4:0] step_t;

  typedef enum logic [0:0] {
    COND_NONE,
    COND_ACC_NONPOS
  } cond_t;

  typedef struct packed {
    mul_sel_t mul_sel;
    act_t     act;
    cond_t    cond;
    step_t    target;
    logic     last;
  } ctrl_word_t;

  typedef enum logic [0:0] {
    SEQ_IDLE,
    SEQ_RUN
  } state_t;

  localparam step_t STEP_ZERO = 5'd16;
  localparam step_t STEP_LAST = 5'd16;

  // Control program: multiplier operands, register update, jump and end-of-item mark
  function automatic ctrl_word_t program_word(input step_t s);
    ctrl_word_t w;
    w = '{mul_sel: MUL_HOLD, act: ACT_NONE, cond: COND_NONE, target: '0, last: 1'b0};
    case (s)
      5'd0:  begin w.mul_sel = MUL_SAMPLE_LEN;  w.act = ACT_WINDOW;   end
      5'd1:  begin w.act = ACT_TOTAL;                                 end
      5'd2:  begin w.mul_sel = MUL_TOTAL_RECIP;                       end
      5'd3:  begin w.act = ACT_AVERAGE;                               end
      5'd4:  begin w.mul_sel = MUL_MAG_SPEED;   w.act = ACT_SETPOINT; end
      5'd5:  begin w.mul_sel = MUL_MAG_RECIP7;  w.act = ACT_SPEED;    end
      5'd6:  begin w.act = ACT_ERROR;                                 end
      5'd7:  begin w.act = ACT_INTEGRAL;                              end
      5'd8:  begin w.mul_sel = MUL_ERR_KP;      w.act = ACT_MAGS;     end
      5'd9:  begin w.mul_sel = MUL_INT_LO_KI;   w.act = ACT_ACC_ERR;  end
      5'd10: begin w.mul_sel = MUL_INT_HI_KI;   w.act = ACT_ACC_INT_LO; end
      5'd11: begin w.mul_sel = MUL_DER_KD;      w.act = ACT_ACC_INT_HI; end
      5'd12: begin w.act = ACT_ACC_DER;                               end
      5'd13: begin
        w.act    = ACT_CLAMP;
        w.cond   = COND_ACC_NONPOS;
        w.target = STEP_ZERO;
      end
      5'd14: begin w.mul_sel = MUL_LEVEL_SCALE;                       end
      5'd15: begin w.act = ACT_FINISH_SCALE;    w.last = 1'b1;        end
      5'd16: begin w.act = ACT_FINISH_ZERO;     w.last = 1'b1;        end
      default: ;
    endcase
    return w;
  endfunction

  state_t     state;
  step_t      step;
  ctrl_word_t word;
  logic       running;
  logic       accept;
  logic       slot_free;
  logic       publish;
  logic       hold_step;
  logic       take_jump;

  assign running   = (state == SEQ_RUN);
  assign word      = program_word(step);
  assign in_stall  = running;
  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;
  assign hold_step = running && word.last && !slot_free;
  assign publish   = running && word.last && slot_free;
  assign take_jump = (word.cond == COND_ACC_NONPOS) && acc_nonpos;

  // Drive the datapath; suppress the update of a final step that must wait for the output
  always_comb begin
    ctrl.start   = accept;
    ctrl.mul_sel = running ? word.mul_sel : MUL_HOLD;
    ctrl.act     = (running && !hold_step) ? word.act : ACT_NONE;
  end

  // Step through the program and hand results over to the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= SEQ_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (publish) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        SEQ_IDLE: begin
          if (accept) begin
            state <= SEQ_RUN;
            step  <= '0;
          end
        end
        SEQ_RUN: begin
          if (word.last) begin
            if (slot_free) begin
              state <= SEQ_IDLE;
            end
          end else if (take_jump) begin
            step <= word.target;
          end else begin
            step <= step + 5'd1;
          end
        end
        default: state <= SEQ_IDLE;
      endcase
    end
  end

  // A result is only published into a free output register
  a_publish_free: assert property (@(posedge clk) disable iff (rst)
    publish |-> !(out_valid && out_stall))
    else $error("result published over a waiting result");

  // A transfer starts the program at its first step
  a_start_step: assert property (@(posedge clk) disable iff (rst)
    accept |=> (running && step == '0))
    else $error("program did not start at step zero");

  // The step counter stays inside the program
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    running |-> (step <= STEP_LAST))
    else $error("step counter left the program");

endmodule

`default_nettype wire
